// ===== rtl/core/lie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and constants of the LCP interval enumerator.
// ----------------------------------------------------------------------------
package lie_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned MAX_RESULTS     = 64;
  localparam int unsigned RB_AW           = $clog2(MAX_RESULTS);
  localparam int unsigned RC_W            = RB_AW + 1;
  localparam int unsigned APB_AW          = 3;
  localparam int unsigned APB_DW          = 32;
  localparam logic        REG_TEXT_LEN    = 1'b0;
  localparam logic [DATA_W-1:0] TEXT_LEN_RST = DATA_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MRD,
    S_MCHK,
    S_GRD,
    S_GCHK,
    S_GWR,
    S_PRD,
    S_PCHK,
    S_PPUSH,
    S_LPUSH,
    S_FRD,
    S_FCHK,
    S_FIN,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic load;
    logic ms_rd;
    logic mg_init;
    logic mg_step;
    logic mg_wr;
    logic pend_leaf;
    logic ps_rd;
    logic pop_emit;
    logic ps_push;
    logic leaf_push;
    logic flush_emit;
    logic finish;
    logic flushing;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic mp_gt1;
    logic lcp_gt;
    logic mg_stop;
    logic pp_nz;
    logic contained;
    logic last;
    logic drain_done;
  } sts_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lcp;
  } ms_ent_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } ps_ent_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] pd;
    logic              hp;
  } rb_ent_t;

endpackage
`default_nettype wire

// ===== rtl/core/lie_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_in_if
// Request channel carrying one suffix-array rank.
// ----------------------------------------------------------------------------
interface lie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] suffix_start;
  logic [31:0] lcp_value;
  logic        last_item;

  modport source (output valid, suffix_start, lcp_value, last_item, input ready);
  modport sink (input valid, suffix_start, lcp_value, last_item, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lie_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_out_if
// Result channel carrying one emitted LCP interval.
// ----------------------------------------------------------------------------
interface lie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_start;
  logic [31:0] interval_end;
  logic [31:0] parent_depth;
  logic        has_parent;
  logic        last_result;
  logic        overflow;

  modport source (output valid, interval_start, interval_end, parent_depth, has_parent,
                  last_result, overflow, input ready);
  modport sink (input valid, interval_start, interval_end, parent_depth, has_parent,
                last_result, overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lcp_interval_enumerator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_interval_enumerator
// Bottom-up LCP interval traversal over suffix-array ranks.
// ----------------------------------------------------------------------------
// Ranks arrive in order on item_i, one request per rank, each with its
// suffix-array value, LCP value and an end-of-text mark. Intervals leave on
// res_o, one request per interval, the last of a rank marked by last_result.
// The text length register is written through the APB port at address 0;
// the user must write it only while the block is idle, which the block does
// not enforce itself; it resets to 1. One rank is processed at a time: it is
// loaded, then while the merge stack holds more than one entry and its top
// LCP exceeds the rank's, equal-LCP entries are merged and written back.
// Contained pending entries are popped and emitted and the new pending entry
// pushed; after a merge this repeats, else the leaf is pushed. At end of text
// all merges complete and the pending stack is flushed. Results of a rank are
// collected in a 64-entry buffer and drained afterward, since each result
// carries the overflow flag as it stands at the end of the rank. The drain
// loads them into the output register; a stalled receiver holds that register
// and pauses the drain. The next rank is accepted once the last result is loaded.
// Reset empties both stacks and the rank counter; stack contents are not
// cleared and need no clearing pass. End of text does the same.
module lcp_interval_enumerator import lie_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lie_in_if.sink            item_i,
  lie_out_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t              cmd;
  sts_t              sts;
  rb_ent_t           out_ent;
  logic [DATA_W-1:0] text_len_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_LEN) ? text_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len_q <= TEXT_LEN_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_LEN) begin
      text_len_q <= pwdata;
    end
  end

  lie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lie_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .text_len_i     (text_len_q),
    .suffix_start_i (item_i.suffix_start),
    .lcp_value_i    (item_i.lcp_value),
    .last_item_i    (item_i.last_item),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .out_ent_o      (out_ent),
    .out_last_o     (res_o.last_result),
    .out_ovf_o      (res_o.overflow)
  );

  assign res_o.interval_start = out_ent.lo;
  assign res_o.interval_end   = out_ent.hi;
  assign res_o.parent_depth   = out_ent.pd;
  assign res_o.has_parent     = out_ent.hp;

endmodule
`default_nettype wire

// ===== rtl/core/lie_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_ctrl
// Sequencer that steps the datapath through merge, pend, flush and drain.
// ----------------------------------------------------------------------------
module lie_ctrl import lie_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   ret_merge_q, flushing_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_MRD;
      S_MRD: begin
        if (sts_i.mp_gt1) state_d = S_MCHK;
        else if (flushing_q) state_d = S_FRD;
        else state_d = S_PRD;
      end
      S_MCHK:  state_d = (flushing_q || sts_i.lcp_gt) ? S_GRD : S_PRD;
      S_GRD:   state_d = S_GCHK;
      S_GCHK:  state_d = sts_i.mg_stop ? S_GWR : S_GRD;
      S_GWR:   state_d = S_PRD;
      S_PRD:   state_d = sts_i.pp_nz ? S_PCHK : S_PPUSH;
      S_PCHK:  state_d = sts_i.contained ? S_PRD : S_PPUSH;
      S_PPUSH: state_d = ret_merge_q ? S_MRD : S_LPUSH;
      S_LPUSH: state_d = sts_i.last ? S_MRD : S_FIN;
      S_FRD:   state_d = sts_i.pp_nz ? S_FCHK : S_FIN;
      S_FCHK:  state_d = S_FRD;
      S_FIN:   state_d = S_DRAIN;
      S_DRAIN: if (sts_i.drain_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.flushing = flushing_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_MRD: begin
        if (sts_i.mp_gt1) cmd_o.ms_rd = 1'b1;
        else if (!flushing_q) cmd_o.pend_leaf = 1'b1;
      end
      S_MCHK: begin
        if (flushing_q || sts_i.lcp_gt) cmd_o.mg_init = 1'b1;
        else cmd_o.pend_leaf = 1'b1;
      end
      S_GRD:   cmd_o.ms_rd = 1'b1;
      S_GCHK:  cmd_o.mg_step = 1'b1;
      S_GWR:   cmd_o.mg_wr = 1'b1;
      S_PRD:   cmd_o.ps_rd = sts_i.pp_nz;
      S_PCHK:  cmd_o.pop_emit = sts_i.contained;
      S_PPUSH: cmd_o.ps_push = 1'b1;
      S_LPUSH: cmd_o.leaf_push = 1'b1;
      S_FRD:   cmd_o.ps_rd = sts_i.pp_nz;
      S_FCHK:  cmd_o.flush_emit = 1'b1;
      S_FIN:   cmd_o.finish = 1'b1;
      S_DRAIN: cmd_o.drain = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_merge_q <= 1'b0;
      flushing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.mg_wr) ret_merge_q <= 1'b1;
      else if (cmd_o.pend_leaf) ret_merge_q <= 1'b0;
      if (state_q == S_LPUSH && sts_i.last) flushing_q <= 1'b1;
      else if (state_q == S_FIN) flushing_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lie_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_dp
// Datapath: merge stack, pending stack, result buffer and output register.
// ----------------------------------------------------------------------------
module lie_dp import lie_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [DATA_W-1:0] text_len_i,
  input  logic [DATA_W-1:0] suffix_start_i,
  input  logic [DATA_W-1:0] lcp_value_i,
  input  logic              last_item_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output rb_ent_t           out_ent_o,
  output logic              out_last_o,
  output logic              out_ovf_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);
  localparam logic [RC_W-1:0] MAX_P = RC_W'(MAX_RESULTS);

  ms_ent_t ms_mem [STACK_DEPTH];
  ps_ent_t ps_mem [STACK_DEPTH];
  rb_ent_t rb_mem [MAX_RESULTS];

  ms_ent_t msr_q;
  ps_ent_t psr_q;
  logic [PW-1:0]     mp_q, pp_q, mp_m1, pp_m1;
  logic [DATA_W-1:0] rank_q, lcp_q, leaf_q, key_q, ns_q, ne_q, nl_q;
  logic [DATA_W-1:0] pa_s_q, pa_e_q, pa_d_q;
  logic              last_q, ovf_q, sovf_q;
  logic [RC_W-1:0]   rc_q, di_q;
  logic              emit_en, ms_we, out_ld, out_free;
  ms_ent_t           ms_wd;
  logic [AW-1:0]     ms_wa;
  rb_ent_t           rb_wd;

  assign mp_m1 = mp_q - PW'(1);
  assign pp_m1 = pp_q - PW'(1);

  assign sts_o.mp_gt1     = mp_q > PW'(1);
  assign sts_o.lcp_gt     = msr_q.lcp > lcp_q;
  assign sts_o.mg_stop    = (msr_q.lcp != key_q) || (mp_q == PW'(1));
  assign sts_o.pp_nz      = pp_q != '0;
  assign sts_o.contained  = (pa_s_q <= psr_q.lo) && (psr_q.hi <= pa_e_q);
  assign sts_o.last       = last_q;
  assign sts_o.drain_done = di_q == rc_q;

  assign emit_en = cmd_i.pop_emit || cmd_i.flush_emit;
  assign rb_wd   = '{lo: psr_q.lo, hi: psr_q.hi,
                     pd: cmd_i.pop_emit ? pa_d_q : '0, hp: cmd_i.pop_emit};

  always_comb begin
    ms_we = 1'b0;
    ms_wa = mp_q[AW-1:0];
    ms_wd = '{lo: ns_q, hi: ne_q, lcp: nl_q};
    if (cmd_i.mg_wr) begin
      ms_we = 1'b1;
    end else if (cmd_i.leaf_push && mp_q < DEPTH_P) begin
      ms_we = 1'b1;
      ms_wd = '{lo: rank_q, hi: rank_q, lcp: lcp_q};
    end
  end

  assign out_free = !out_valid_o || out_ready_i;
  assign out_ld   = cmd_i.drain && out_free && (di_q != rc_q);

  always_ff @(posedge clk_i) begin
    if (ms_we) ms_mem[ms_wa] <= ms_wd;
    if (cmd_i.ms_rd) msr_q <= ms_mem[mp_m1[AW-1:0]];
    if (cmd_i.ps_push && pp_q < DEPTH_P) ps_mem[pp_q[AW-1:0]] <= '{lo: pa_s_q, hi: pa_e_q};
    if (cmd_i.ps_rd) psr_q <= ps_mem[pp_m1[AW-1:0]];
    if (emit_en && rc_q != MAX_P) rb_mem[rc_q[RB_AW-1:0]] <= rb_wd;
    if (out_ld) begin
      out_ent_o  <= rb_mem[di_q[RB_AW-1:0]];
      out_last_o <= (di_q + RC_W'(1)) == rc_q;
      out_ovf_o  <= sovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lcp_q  <= lcp_value_i;
      last_q <= last_item_i;
      leaf_q <= text_len_i - suffix_start_i;
    end
    if (cmd_i.mg_init) begin
      key_q <= msr_q.lcp;
      ne_q  <= msr_q.hi;
    end
    if (cmd_i.mg_step) begin
      ns_q <= msr_q.lo;
      nl_q <= msr_q.lcp;
    end
    if (cmd_i.pend_leaf) begin
      pa_s_q <= rank_q;
      pa_e_q <= rank_q;
      pa_d_q <= leaf_q;
    end else if (cmd_i.mg_wr) begin
      pa_s_q <= ns_q;
      pa_e_q <= ne_q;
      pa_d_q <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q        <= '0;
      pp_q        <= '0;
      rank_q      <= '0;
      ovf_q       <= 1'b0;
      sovf_q      <= 1'b0;
      rc_q        <= '0;
      di_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rc_q <= '0;
        di_q <= '0;
      end
      if (cmd_i.mg_init || cmd_i.mg_step) mp_q <= mp_m1;
      if (cmd_i.mg_wr) mp_q <= mp_q + PW'(1);
      if (cmd_i.leaf_push) begin
        rank_q <= rank_q + DATA_W'(1);
        if (mp_q < DEPTH_P) mp_q <= mp_q + PW'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.ps_push) begin
        if (pp_q < DEPTH_P) pp_q <= pp_q + PW'(1);
        else ovf_q <= 1'b1;
      end
      if (emit_en) begin
        pp_q <= pp_m1;
        if (rc_q != MAX_P) rc_q <= rc_q + RC_W'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        sovf_q <= ovf_q;
        if (cmd_i.flushing) begin
          rank_q <= '0;
          mp_q   <= '0;
          pp_q   <= '0;
          ovf_q  <= 1'b0;
        end
      end
      if (out_ld) begin
        out_valid_o <= 1'b1;
        di_q        <= di_q + RC_W'(1);
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lie_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lie_chk
// Port-level checks of the LCP interval enumerator.
// ----------------------------------------------------------------------------
module lie_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_start,
  input logic [31:0] out_depth,
  input logic        out_hp
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result valid dropped");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_start)) else $error("result changed");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second request taken");

  a_root_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_hp |-> out_depth == '0) else $error("root with depth");

endmodule

bind lcp_interval_enumerator lie_chk u_lie_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (item_i.valid),
  .in_ready  (item_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_start (res_o.interval_start),
  .out_depth (res_o.parent_depth),
  .out_hp    (res_o.has_parent)
);
`default_nettype wire
